FILE: hw/rtl/hwin_pkg.sv
// Shared constants, region codes and the sine table generator for the
// tapered window unit. No dependencies.
package hwin_pkg;

  localparam int MAX_WINDOWS       = 2;
  localparam int NUM_WINDOWS_DEF   = 2;
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int POSITION_BITS_DEF = 16;
  localparam int SINE_DEPTH_DEF    = 256;

  localparam int WEIGHT_BITS   = 16;
  localparam int CONTRIB_BITS  = 18;
  localparam int COUNT_BITS    = 2;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [WEIGHT_BITS-1:0] UNITY_Q15 = 16'd32768;

  typedef enum logic [2:0] {
    REG_COUNT  = 3'd0,
    REG_W0_LOW = 3'd1,
    REG_W0_HI  = 3'd2,
    REG_W0_TAP = 3'd3,
    REG_W1_LOW = 3'd4,
    REG_W1_HI  = 3'd5,
    REG_W1_TAP = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    RG_BELOW = 3'd0,
    RG_RISE  = 3'd1,
    RG_FLAT  = 3'd2,
    RG_FALL  = 3'd3,
    RG_ABOVE = 3'd4
  } region_t;

  // Clocks from an accepted word to its result strobe.
  function automatic int latency(int depth);
    return $clog2(depth + 1) + 4;
  endfunction

  // Taylor series of sin(a), a in Q2.30, eight terms past the first.
  function automatic logic [WEIGHT_BITS-1:0] sine_q15(longint unsigned a);
    longint unsigned mag;
    longint          sum;
    longint unsigned v;
    int              n;
    mag = a;
    sum = longint'(a);
    for (n = 1; n <= 8; n++) begin
      mag = (mag * a) >> 30;
      mag = (mag * a) >> 30;
      case (n)
        1: mag = mag / 6;
        2: mag = mag / 20;
        3: mag = mag / 42;
        4: mag = mag / 72;
        5: mag = mag / 110;
        6: mag = mag / 156;
        7: mag = mag / 210;
        default: mag = mag / 272;
      endcase
      if (n % 2 == 1) sum = sum - longint'(mag);
      else            sum = sum + longint'(mag);
    end
    if (sum < 0) sum = 0;
    v = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
    if (v > 32768) v = 32768;
    return v[WEIGHT_BITS-1:0];
  endfunction

endpackage

FILE: hw/rtl/hwin_lane.sv
// One window lane: region decode, pipelined taper divide, sine lookup.
// Depends on hwin_pkg.
module hwin_lane #(
  parameter int POSITION_BITS    = hwin_pkg::POSITION_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = hwin_pkg::SINE_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    active,
  input  logic [POSITION_BITS-1:0]                position,
  input  logic [POSITION_BITS-1:0]                low_edge,
  input  logic [POSITION_BITS-1:0]                high_edge,
  input  logic [POSITION_BITS-1:0]                taper,
  output logic signed [hwin_pkg::CONTRIB_BITS-1:0] contrib
);
  import hwin_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int D  = SINE_TABLE_DEPTH;
  localparam int QB = $clog2(D + 1);
  localparam int MW = $clog2(4 * D + 1);
  localparam int NW = PW + MW + 1;
  localparam int CW = NW + QB + 1;
  localparam int SW = PW + 3;

  logic [WEIGHT_BITS-1:0] rom [D+1];

  for (genvar g = 0; g <= D; g++) begin : g_rom
    localparam longint unsigned ANGLE = (longint'(g) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign rom[g] = sine_q15(ANGLE);
  end

  // Region decode at twice the position resolution
  logic signed [SW-1:0] xx, lo2, hi2, tt;
  logic signed [PW:0]   d;
  logic [PW:0]          ad;
  logic [CW-1:0]        num;
  region_t              region_in;

  always_comb begin
    xx  = SW'($signed({2'b00, position, 1'b0}));
    lo2 = SW'($signed({2'b00, low_edge, 1'b0}));
    hi2 = SW'($signed({2'b00, high_edge, 1'b0}));
    tt  = SW'($signed({3'b000, taper}));
    if (!active)               region_in = RG_BELOW;
    else if (xx < lo2 - tt)    region_in = RG_BELOW;
    else if (xx < lo2 + tt)    region_in = RG_RISE;
    else if (xx < hi2 - tt)    region_in = RG_FLAT;
    else if (xx < hi2 + tt)    region_in = RG_FALL;
    else                       region_in = RG_ABOVE;
    if (region_in == RG_FALL) d = $signed({1'b0, position}) - $signed({1'b0, high_edge});
    else                      d = $signed({1'b0, position}) - $signed({1'b0, low_edge});
    ad  = d[PW] ? (PW+1)'(-d) : (PW+1)'(d);
    num = CW'(ad[PW-1:0]) * CW'(4 * D) + CW'(taper);
  end

  logic [CW-1:0] rem      [QB+1];
  logic [QB-1:0] quo      [QB+1];
  region_t       region_s [QB+1];
  logic          neg_s    [QB+1];

  always_ff @(posedge clk) begin
    rem[0]      <= num;
    quo[0]      <= '0;
    region_s[0] <= region_in;
    neg_s[0]    <= d[PW];
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [CW-1:0] den;
    assign den = CW'({taper, 1'b0}) << B;
    always_ff @(posedge clk) begin
      region_s[k+1] <= region_s[k];
      neg_s[k+1]    <= neg_s[k];
      if (rem[k] >= den) begin
        rem[k+1] <= rem[k] - den;
        quo[k+1] <= quo[k] | (QB'(1) << B);
      end else begin
        rem[k+1] <= rem[k];
        quo[k+1] <= quo[k];
      end
    end
  end

  logic [QB-1:0]                  idx;
  logic signed [CONTRIB_BITS-1:0] sine_s;
  logic signed [CONTRIB_BITS-1:0] contrib_next;

  always_comb begin
    idx    = (quo[QB] > QB'(D)) ? QB'(D) : quo[QB];
    sine_s = $signed({2'b00, rom[idx]});
    if (neg_s[QB]) sine_s = -sine_s;
    case (region_s[QB])
      RG_RISE: contrib_next = CONTRIB_BITS'(32768) + sine_s;
      RG_FLAT: contrib_next = CONTRIB_BITS'(65536);
      RG_FALL: contrib_next = CONTRIB_BITS'(32768) - sine_s;
      default: contrib_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    contrib <= contrib_next;
  end

endmodule

FILE: hw/rtl/hwin_merge.sv
// Merge stage: sums lane weights, clamps, forces unity weight on a config error, scales both samples.
// Depends on hwin_pkg.
module hwin_merge #(
  parameter int NUM_WINDOWS = hwin_pkg::NUM_WINDOWS_DEF,
  parameter int SAMPLE_BITS = hwin_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                     clk,
  input  logic signed [hwin_pkg::CONTRIB_BITS-1:0] contrib [NUM_WINDOWS],
  input  logic                                     err,
  input  logic signed [SAMPLE_BITS-1:0]            sa,
  input  logic signed [SAMPLE_BITS-1:0]            sb,
  output logic signed [SAMPLE_BITS-1:0]            out_a,
  output logic signed [SAMPLE_BITS-1:0]            out_b,
  output logic [hwin_pkg::WEIGHT_BITS-1:0]         weight,
  output logic                                     config_error
);
  import hwin_pkg::*;

  localparam int SUMW = CONTRIB_BITS + 1;

  logic signed [SUMW-1:0]   sum;
  logic [16:0]              clamped;
  logic [17:0]              rnd;
  logic [WEIGHT_BITS-1:0]   w_next;

  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_WINDOWS; j++) sum = sum + SUMW'(contrib[j]);
    if (sum > SUMW'(65536))  clamped = 17'd65536;
    else if (sum < 0)        clamped = '0;
    else                     clamped = sum[16:0];
    rnd = {1'b0, clamped} + 18'd1;
    // unity weight passes the samples through unchanged
    w_next = err ? UNITY_Q15 : rnd[16:1];
  end

  logic [WEIGHT_BITS-1:0]         w_q;
  logic                           err_q;
  logic signed [SAMPLE_BITS-1:0]  sa_q, sb_q;

  always_ff @(posedge clk) begin
    w_q   <= w_next;
    err_q <= err;
    sa_q  <= sa;
    sb_q  <= sb;
  end

  localparam int PRW = SAMPLE_BITS + 1 + WEIGHT_BITS;

  function automatic logic [SAMPLE_BITS-1:0] scale(logic signed [SAMPLE_BITS-1:0] s,
                                                    logic [WEIGHT_BITS-1:0] w);
    logic [SAMPLE_BITS:0] mag;
    logic [PRW-1:0]       prod;
    logic [SAMPLE_BITS:0] r;
    mag  = s[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(-$signed({s[SAMPLE_BITS-1], s}))
                            : (SAMPLE_BITS+1)'({1'b0, s});
    prod = PRW'(mag) * PRW'(w) + PRW'(16384);
    r    = prod[15 +: SAMPLE_BITS+1];
    if (s[SAMPLE_BITS-1]) r = -r;
    return r[SAMPLE_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    out_a        <= $signed(scale(sa_q, w_q));
    out_b        <= $signed(scale(sb_q, w_q));
    weight       <= w_q;
    config_error <= err_q;
  end

endmodule

FILE: hw/rtl/multi_segment_hann_taper_window_unit.sv
// Tapered window unit: a word enters every cycle, busy is high only during reset.
// Pipeline: region register, the bit-per-stage taper divide in each lane, lookup
// register and two merge stages, in that order.
// Throughput: one word per cycle; the receiver cannot stall, done pulses once per word.
// Reset: synchronous, clears the valid pipeline and the window registers to zero.
module multi_segment_hann_taper_window_unit #(
  parameter int NUM_WINDOWS      = hwin_pkg::NUM_WINDOWS_DEF,
  parameter int SAMPLE_BITS      = hwin_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS    = hwin_pkg::POSITION_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = hwin_pkg::SINE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [POSITION_BITS-1:0]           position,
  input  logic signed [SAMPLE_BITS-1:0]      sample_a,
  input  logic signed [SAMPLE_BITS-1:0]      sample_b,
  output logic                               done,
  output logic signed [SAMPLE_BITS-1:0]      out_a,
  output logic signed [SAMPLE_BITS-1:0]      out_b,
  output logic [hwin_pkg::WEIGHT_BITS-1:0]   weight,
  output logic                               config_error,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hwin_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [hwin_pkg::DATA_BITS-1:0]     pwdata,
  output logic [hwin_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready
);
  import hwin_pkg::*;

  localparam int PW       = POSITION_BITS;
  localparam int LAT      = latency(SINE_TABLE_DEPTH);
  localparam int LANE_LAT = LAT - 2;

  logic [COUNT_BITS-1:0] window_count;
  logic [PW-1:0]         win_low   [MAX_WINDOWS];
  logic [PW-1:0]         win_high  [MAX_WINDOWS];
  logic [PW-1:0]         win_taper [MAX_WINDOWS];

  reg_index_t reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign busy    = rst;
  assign reg_sel = reg_index_t'(paddr[ADDR_BITS-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      for (int j = 0; j < MAX_WINDOWS; j++) begin
        win_low[j]   <= '0;
        win_high[j]  <= '0;
        win_taper[j] <= '0;
      end
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_COUNT:  window_count <= pwdata[COUNT_BITS-1:0];
        REG_W0_LOW: win_low[0]   <= pwdata[PW-1:0];
        REG_W0_HI:  win_high[0]  <= pwdata[PW-1:0];
        REG_W0_TAP: win_taper[0] <= pwdata[PW-1:0];
        REG_W1_LOW: win_low[1]   <= pwdata[PW-1:0];
        REG_W1_HI:  win_high[1]  <= pwdata[PW-1:0];
        REG_W1_TAP: win_taper[1] <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COUNT:  prdata = DATA_BITS'(window_count);
      REG_W0_LOW: prdata = DATA_BITS'(win_low[0]);
      REG_W0_HI:  prdata = DATA_BITS'(win_high[0]);
      REG_W0_TAP: prdata = DATA_BITS'(win_taper[0]);
      REG_W1_LOW: prdata = DATA_BITS'(win_low[1]);
      REG_W1_HI:  prdata = DATA_BITS'(win_high[1]);
      REG_W1_TAP: prdata = DATA_BITS'(win_taper[1]);
      default:    prdata = '0;
    endcase
  end

  // Saturate the count; the user must hold config steady while words are in flight, the block does not enforce it
  logic [COUNT_BITS-1:0]  count_sat;
  logic [NUM_WINDOWS-1:0] active;
  logic                   err;

  always_comb begin
    count_sat = (window_count > COUNT_BITS'(NUM_WINDOWS)) ? COUNT_BITS'(NUM_WINDOWS)
                                                          : window_count;
    err = 1'b0;
    for (int j = 0; j < NUM_WINDOWS; j++) begin
      active[j] = COUNT_BITS'(j) < count_sat;
      if (active[j] && ({1'b0, win_high[j]} < {1'b0, win_low[j]} + {1'b0, win_taper[j]}))
        err = 1'b1;
    end
  end

  logic signed [CONTRIB_BITS-1:0] contrib [NUM_WINDOWS];

  for (genvar j = 0; j < NUM_WINDOWS; j++) begin : g_lane
    hwin_lane #(
      .POSITION_BITS    (POSITION_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_lane (
      .clk       (clk),
      .active    (active[j]),
      .position  (position),
      .low_edge  (win_low[j]),
      .high_edge (win_high[j]),
      .taper     (win_taper[j]),
      .contrib   (contrib[j])
    );
  end

  // Sample delay line matching the lane depth
  logic signed [SAMPLE_BITS-1:0] sa_d [LANE_LAT];
  logic signed [SAMPLE_BITS-1:0] sb_d [LANE_LAT];

  always_ff @(posedge clk) begin
    sa_d[0] <= sample_a;
    sb_d[0] <= sample_b;
    for (int k = 1; k < LANE_LAT; k++) begin
      sa_d[k] <= sa_d[k-1];
      sb_d[k] <= sb_d[k-1];
    end
  end

  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[LAT-2:0], start && !busy};
  end

  assign done = vld[LAT-1];

  hwin_merge #(
    .NUM_WINDOWS (NUM_WINDOWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk          (clk),
    .contrib      (contrib),
    .err          (err),
    .sa           (sa_d[LANE_LAT-1]),
    .sb           (sb_d[LANE_LAT-1]),
    .out_a        (out_a),
    .out_b        (out_b),
    .weight       (weight),
    .config_error (config_error)
  );

endmodule

FILE: hw/rtl/hwin_checker.sv
// Port-level checks for the tapered window unit, bound to the top level.
// Depends on hwin_pkg.
module hwin_checker #(
  parameter int SAMPLE_BITS      = hwin_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = hwin_pkg::SINE_DEPTH_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [SAMPLE_BITS-1:0]           out_a,
  input logic [SAMPLE_BITS-1:0]           out_b,
  input logic [hwin_pkg::WEIGHT_BITS-1:0] weight,
  input logic                             config_error
);
  import hwin_pkg::*;

  localparam int LAT = latency(SINE_TABLE_DEPTH);

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done) else $error("word result missing at fixed latency");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    done |-> weight <= UNITY_Q15) else $error("weight above unity");

  a_error_unity: assert property (@(posedge clk) disable iff (rst)
    (done && config_error) |-> weight == UNITY_Q15) else $error("error word not unity");

  a_zero_weight: assert property (@(posedge clk) disable iff (rst)
    (done && weight == '0) |-> (out_a == '0 && out_b == '0))
    else $error("nonzero sample at zero weight");

endmodule

bind multi_segment_hann_taper_window_unit hwin_checker #(
  .SAMPLE_BITS      (SAMPLE_BITS),
  .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
) u_hwin_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .out_a        (out_a),
  .out_b        (out_b),
  .weight       (weight),
  .config_error (config_error)
);
